// File: rtl/tdon_pkg.sv
`default_nettype none

package tdon_pkg;

    localparam int SEC_FRAC_BITS = 16;
    localparam int SEC_W         = 6 + SEC_FRAC_BITS;
    localparam int S_TDATA_W     = 64;
    localparam int S_TUSER_W     = 1;
    localparam int M_TDATA_W     = 48;

    localparam logic [SEC_W:0] SEC_UNIT = (SEC_W + 1)'(60) << SEC_FRAC_BITS;

    localparam logic        OP_ADD  = 1'b0;
    localparam logic        OP_LOAD = 1'b1;

    // floor divide by a constant: bias to non-negative, reciprocal multiply, one correction
    localparam logic [18:0] BIAS60  = 19'd131100;
    localparam logic [13:0] RECIP60 = 14'd8738;
    localparam logic [18:0] BIAS24  = 19'd131088;
    localparam logic [14:0] RECIP24 = 15'd21845;
    localparam logic signed [13:0] BIASQ60 = 14'sd2185;
    localparam logic signed [13:0] BIASQ24 = 14'sd5462;

    typedef struct packed {
        logic                opcode;
        logic signed [15:0]  hour_delta;
        logic signed [15:0]  minute_delta;
        logic signed [31:0]  second_delta;
    } tdon_in_t;

    typedef struct packed {
        logic signed [13:0]  quo;
        logic [5:0]          rem;
    } tdon_divmod_t;

    typedef struct packed {
        logic                opcode;
        logic signed [15:0]  hour_delta;
        logic signed [15:0]  minute_delta;
        logic signed [13:0]  carry;
        logic [SEC_W-1:0]    dsec;
    } tdon_stage_b_t;

    typedef struct packed {
        logic                opcode;
        logic signed [15:0]  hour_delta;
        logic signed [13:0]  carry;
        logic [5:0]          dmin;
        logic [SEC_W-1:0]    dsec;
    } tdon_stage_c_t;

    typedef struct packed {
        logic                opcode;
        logic signed [13:0]  dday;
        logic [4:0]          dhour;
        logic [5:0]          dmin;
        logic [SEC_W-1:0]    dsec;
    } tdon_dnorm_t;

    typedef struct packed {
        logic signed [11:0]  day_carry;
        logic [SEC_W-1:0]    second_now;
        logic [5:0]          minute_now;
        logic [4:0]          hour_now;
    } tdon_result_t;

    function automatic tdon_divmod_t divmod60(input logic signed [17:0] x);
        logic [18:0]  u;
        logic [32:0]  prod;
        logic [13:0]  q;
        logic [19:0]  r;
        tdon_divmod_t res;
        u    = 19'($signed({x[17], x}) + $signed(BIAS60));
        prod = 33'(u) * 33'(RECIP60);
        q    = prod[32:19];
        r    = 20'(u) - (20'({q, 6'b0}) - 20'({q, 2'b0}));
        if (r >= 20'd60)
        begin
            q = q + 14'd1;
            r = r - 20'd60;
        end
        res.quo = $signed(q) - BIASQ60;
        res.rem = r[5:0];
        return res;
    endfunction

    function automatic tdon_divmod_t divmod24(input logic signed [17:0] x);
        logic [18:0]  u;
        logic [33:0]  prod;
        logic [14:0]  q;
        logic [19:0]  r;
        tdon_divmod_t res;
        u    = 19'($signed({x[17], x}) + $signed(BIAS24));
        prod = 34'(u) * 34'(RECIP24);
        q    = prod[33:19];
        r    = 20'(u) - (20'({q, 4'b0}) + 20'({q, 3'b0}));
        if (r >= 20'd24)
        begin
            q = q + 15'd1;
            r = r - 20'd24;
        end
        res.quo = $signed(q[13:0]) - BIASQ24;
        res.rem = r[5:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tdon_delta_norm.sv
`default_nettype none

module tdon_delta_norm
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_valid,
    output      logic                   s_ready,
    input  wire tdon_pkg::tdon_in_t     s_item,
    output      logic                   d_valid,
    input  wire logic                   d_ready,
    output      tdon_pkg::tdon_dnorm_t  d_item
);

    tdon_pkg::tdon_in_t      a_reg;
    tdon_pkg::tdon_stage_b_t b_reg, b_next;
    tdon_pkg::tdon_stage_c_t c_reg, c_next;
    tdon_pkg::tdon_dnorm_t   d_reg, d_next;
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic ready_a, ready_b, ready_c, ready_d;

    logic signed [31:0]     sec_whole;
    tdon_pkg::tdon_divmod_t sec_dm, min_dm, hour_dm;
    logic signed [17:0]     min_sum, hour_sum;

    assign ready_d = !d_valid_reg || d_ready;
    assign ready_c = !c_valid_reg || ready_d;
    assign ready_b = !b_valid_reg || ready_c;
    assign ready_a = !a_valid_reg || ready_b;
    assign s_ready = ready_a;
    assign d_valid = d_valid_reg;
    assign d_item  = d_reg;

    // seconds: floor by 2^F is a shift, then floor by 60
    always_comb
    begin
        sec_whole           = a_reg.second_delta >>> tdon_pkg::SEC_FRAC_BITS;
        sec_dm              = tdon_pkg::divmod60(sec_whole[17:0]);
        b_next.opcode       = a_reg.opcode;
        b_next.hour_delta   = a_reg.hour_delta;
        b_next.minute_delta = a_reg.minute_delta;
        b_next.carry        = sec_dm.quo;
        b_next.dsec         = {sec_dm.rem, a_reg.second_delta[tdon_pkg::SEC_FRAC_BITS-1:0]};
    end

    always_comb
    begin
        min_sum           = 18'(b_reg.minute_delta) + 18'(b_reg.carry);
        min_dm            = tdon_pkg::divmod60(min_sum);
        c_next.opcode     = b_reg.opcode;
        c_next.hour_delta = b_reg.hour_delta;
        c_next.carry      = min_dm.quo;
        c_next.dmin       = min_dm.rem;
        c_next.dsec       = b_reg.dsec;
    end

    always_comb
    begin
        hour_sum      = 18'(c_reg.hour_delta) + 18'(c_reg.carry);
        hour_dm       = tdon_pkg::divmod24(hour_sum);
        d_next.opcode = c_reg.opcode;
        d_next.dday   = hour_dm.quo;
        d_next.dhour  = hour_dm.rem[4:0];
        d_next.dmin   = c_reg.dmin;
        d_next.dsec   = c_reg.dsec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                a_valid_reg <= s_valid;
            end
            if (ready_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (ready_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (ready_d)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && s_valid)
        begin
            a_reg <= s_item;
        end
        if (ready_b && a_valid_reg)
        begin
            b_reg <= b_next;
        end
        if (ready_c && b_valid_reg)
        begin
            c_reg <= c_next;
        end
        if (ready_d && c_valid_reg)
        begin
            d_reg <= d_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tdon_accum.sv
`default_nettype none

module tdon_accum
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   d_valid,
    output      logic                   d_ready,
    input  wire tdon_pkg::tdon_dnorm_t  d_item,
    output      logic                   res_valid,
    input  wire logic                   res_ready,
    output      tdon_pkg::tdon_result_t res_item
);

    logic [4:0]                 hour_reg, hour_next;
    logic [5:0]                 minute_reg, minute_next;
    logic [tdon_pkg::SEC_W-1:0] second_reg, second_next;
    logic                       res_valid_reg;
    tdon_pkg::tdon_result_t     res_reg, res_next;

    logic [4:0]                 h0;
    logic [5:0]                 m0;
    logic [tdon_pkg::SEC_W-1:0] s0;
    logic [tdon_pkg::SEC_W:0]   sec_sum;
    logic                       sec_cy, min_cy, hour_cy;
    logic [6:0]                 min_sum;
    logic [5:0]                 hour_sum;
    logic signed [14:0]         days;
    logic                       take;

    assign d_ready   = !res_valid_reg || res_ready;
    assign take      = d_valid && d_ready;
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    // held time and delta are both normalized, so each carry is at most one
    always_comb
    begin
        h0 = (d_item.opcode == tdon_pkg::OP_LOAD) ? 5'd0 : hour_reg;
        m0 = (d_item.opcode == tdon_pkg::OP_LOAD) ? 6'd0 : minute_reg;
        s0 = (d_item.opcode == tdon_pkg::OP_LOAD) ? '0 : second_reg;

        sec_sum = {1'b0, s0} + {1'b0, d_item.dsec};
        sec_cy  = sec_sum >= tdon_pkg::SEC_UNIT;
        if (sec_cy)
        begin
            sec_sum = sec_sum - tdon_pkg::SEC_UNIT;
        end

        min_sum = 7'(m0) + 7'(d_item.dmin) + 7'(sec_cy);
        min_cy  = min_sum >= 7'd60;
        if (min_cy)
        begin
            min_sum = min_sum - 7'd60;
        end

        hour_sum = 6'(h0) + 6'(d_item.dhour) + 6'(min_cy);
        hour_cy  = hour_sum >= 6'd24;
        if (hour_cy)
        begin
            hour_sum = hour_sum - 6'd24;
        end

        days = 15'(d_item.dday) + $signed({14'd0, hour_cy});

        second_next = sec_sum[tdon_pkg::SEC_W-1:0];
        minute_next = min_sum[5:0];
        hour_next   = hour_sum[4:0];

        res_next.hour_now   = hour_next;
        res_next.minute_now = minute_next;
        res_next.second_now = second_next;
        if (days > 15'sd2047)
        begin
            res_next.day_carry = 12'sd2047;
        end
        else if (days < -15'sd2048)
        begin
            res_next.day_carry = -12'sd2048;
        end
        else
        begin
            res_next.day_carry = days[11:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (d_ready)
            begin
                res_valid_reg <= d_valid;
            end
            if (take)
            begin
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/time_of_day_offset_normalizer.sv
// channel   | direction | handshake               | payload
// s_axis    | in        | s_axis_tvalid/tready    | tdata: deltas, tuser: opcode
// m_axis    | out       | m_axis_tvalid/tready    | tdata: time of day, day carry
//
// One transaction per cycle sustained while the output is not stalled.
// Three stages take the deltas apart (seconds by 60, minutes by 60, hours by 24);
// the last stage adds the held time with single-step carries in one combinational pass.
// Stages advance when the one ahead is empty or moving; a stalled output holds its data.
// Reset clears the held time to midnight and empties the pipeline.
`default_nettype none

module time_of_day_offset_normalizer
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    // hour_delta[15:0], minute_delta[31:16], second_delta[63:32]
    input  wire logic [tdon_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // opcode[0]
    input  wire logic [tdon_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // hour_now[4:0], minute_now[10:5], second_now[32:11], day_carry[44:33], zero[47:45]
    output      logic [tdon_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    tdon_pkg::tdon_in_t     in_item;
    tdon_pkg::tdon_dnorm_t  d_item;
    tdon_pkg::tdon_result_t res_item;
    logic                   d_valid, d_ready;

    assign in_item.opcode       = s_axis_tuser[0];
    assign in_item.hour_delta   = s_axis_tdata[15:0];
    assign in_item.minute_delta = s_axis_tdata[31:16];
    assign in_item.second_delta = s_axis_tdata[63:32];

    tdon_delta_norm u_norm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (in_item),
        .d_valid (d_valid),
        .d_ready (d_ready),
        .d_item  (d_item)
    );

    tdon_accum u_accum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .d_valid   (d_valid),
        .d_ready   (d_ready),
        .d_item    (d_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_item  (res_item)
    );

    assign m_axis_tdata = {3'b000, res_item};

endmodule

`default_nettype wire

// File: rtl/tdon_checker.sv
`default_nettype none

module tdon_checker
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [tdon_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input wire logic [tdon_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [tdon_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable({s_axis_tuser, s_axis_tdata}))
        else $error("waiting input transaction changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transaction changed");

    a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:0] < 5'd24)
        else $error("hour out of range");

    a_minute_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[10:5] < 6'd60)
        else $error("minute out of range");

    a_second_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> {1'b0, m_axis_tdata[32:11]} < tdon_pkg::SEC_UNIT)
        else $error("second out of range");

endmodule

bind time_of_day_offset_normalizer tdon_checker u_tdon_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_OFF     = 150;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SMALL_SEC    = 200 * 65536;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [tdon_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic [tdon_pkg::S_TUSER_W-1:0] s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [tdon_pkg::M_TDATA_W-1:0] m_axis_tdata;

    time_of_day_offset_normalizer i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [4:0]                 held_hour;
    logic [5:0]                 held_min;
    logic [tdon_pkg::SEC_W-1:0] held_sec;
    tdon_pkg::tdon_result_t     pending_times[$];
    tdon_pkg::tdon_in_t         stim_rows[$];
    bit                         row_typed[$];
    tdon_pkg::tdon_result_t     row_want[$];
    int                         errors;
    int                         times_checked;
    int                         items_sent;
    int                         loads_sent;
    int                         day_moves;
    int                         burst_left;
    int                         cycles;
    bit                         held_off;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_times.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic longint floor_div(input longint a, input longint d,
                                         output longint r);
        longint q;
        q = a / d;
        r = a % d;
        if (r < 0)
        begin
            r = r + d;
            q = q - 1;
        end
        return q;
    endfunction

    // floor carry and borrow across 60 s, 60 min, 24 h; updates the held time
    function automatic tdon_pkg::tdon_result_t advance_clock(input tdon_pkg::tdon_in_t it);
        longint                 unit_len;
        longint                 h0;
        longint                 m0;
        longint                 s0;
        longint                 sec;
        longint                 min;
        longint                 hour;
        longint                 carry;
        longint                 days;
        tdon_pkg::tdon_result_t res;
        unit_len = longint'(60) <<< tdon_pkg::SEC_FRAC_BITS;
        h0 = longint'(held_hour);
        m0 = longint'(held_min);
        s0 = longint'(held_sec);
        if (it.opcode == tdon_pkg::OP_LOAD)
        begin
            h0 = 0;
            m0 = 0;
            s0 = 0;
        end
        carry = floor_div(s0 + longint'($signed(it.second_delta)), unit_len, sec);
        carry = floor_div(m0 + longint'($signed(it.minute_delta)) + carry, 60, min);
        days  = floor_div(h0 + longint'($signed(it.hour_delta)) + carry, 24, hour);
        if (days > 2047)
            days = 2047;
        if (days < -2048)
            days = -2048;
        held_hour = hour[4:0];
        held_min  = min[5:0];
        held_sec  = sec[tdon_pkg::SEC_W-1:0];
        res.hour_now   = held_hour;
        res.minute_now = held_min;
        res.second_now = held_sec;
        res.day_carry  = days[11:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on result %0d: %s got %0d, want %0d", times_checked, what, got,
                 want);
        errors++;
    endtask

    task automatic add_row(input logic op, input int h, input int m, input int s,
                           input bit typed, input int wh, input int wm, input int ws,
                           input int wd);
        tdon_pkg::tdon_in_t     it;
        tdon_pkg::tdon_result_t want;
        it.opcode       = op;
        it.hour_delta   = 16'(h);
        it.minute_delta = 16'(m);
        it.second_delta = 32'(s);
        want.hour_now   = 5'(wh);
        want.minute_now = 6'(wm);
        want.second_now = ws[tdon_pkg::SEC_W-1:0];
        want.day_carry  = 12'(wd);
        stim_rows.push_back(it);
        row_typed.push_back(typed);
        row_want.push_back(want);
    endtask

    task automatic send_txn(input tdon_pkg::tdon_in_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.second_delta, it.minute_delta, it.hour_delta};
        s_axis_tuser  <= it.opcode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (it.opcode == tdon_pkg::OP_LOAD)
            loads_sent++;
    endtask

    // output monitor
    always @(posedge clk)
    begin
        tdon_pkg::tdon_result_t got;
        tdon_pkg::tdon_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[$bits(tdon_pkg::tdon_result_t)-1:0];
            if (pending_times.size() == 0)
            begin
                $display("result with nothing pending: %0d:%0d:%0d day %0d",
                         got.hour_now, got.minute_now, got.second_now,
                         $signed(got.day_carry));
                errors++;
            end
            else
            begin
                want = pending_times.pop_front();
                if (got.hour_now !== want.hour_now)
                    flag_mismatch("hour_now", got.hour_now, want.hour_now);
                if (got.minute_now !== want.minute_now)
                    flag_mismatch("minute_now", got.minute_now, want.minute_now);
                if (got.second_now !== want.second_now)
                    flag_mismatch("second_now", got.second_now, want.second_now);
                if (got.day_carry !== want.day_carry)
                    flag_mismatch("day_carry", $signed(got.day_carry),
                                  $signed(want.day_carry));
                if (want.day_carry != 0)
                    day_moves++;
            end
            times_checked++;
        end
    end

    // receiver stall pattern, with one long hold-off to back up the pipeline
    initial
    begin
        int mode;
        int span;
        int k;
        m_axis_tready <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            if (!held_off && times_checked >= 120)
            begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            for (k = 0; k < span; k++)
            begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= k[0];
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        tdon_pkg::tdon_in_t     it;
        tdon_pkg::tdon_result_t pred;
        int                     i;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        held_hour = '0;
        held_min  = '0;
        held_sec  = '0;

        //      op                 hour    minute  second        typed  h   m   s        day
        add_row(tdon_pkg::OP_ADD,  0,      0,      0,            1,     0,  0,  0,       0);
        add_row(tdon_pkg::OP_ADD,  0,      0,      3932159,      0,     0,  0,  0,       0);
        add_row(tdon_pkg::OP_ADD,  0,      0,      1,            0,     0,  0,  0,       0);
        add_row(tdon_pkg::OP_ADD,  0,      0,      -1,           0,     0,  0,  0,       0);
        add_row(tdon_pkg::OP_LOAD, 0,      0,      -1,           1,     23, 59, 3932159, -1);
        add_row(tdon_pkg::OP_ADD,  0,      0,      1,            1,     0,  0,  0,       1);
        add_row(tdon_pkg::OP_LOAD, 32767,  0,      0,            1,     7,  0,  0,       1365);
        add_row(tdon_pkg::OP_LOAD, -32768, 0,      0,            1,     16, 0,  0,       -1366);
        add_row(tdon_pkg::OP_LOAD, 0,      32767,  0,            1,     18, 7,  0,       22);
        add_row(tdon_pkg::OP_LOAD, 0,      -32768, 0,            0,     0,  0,  0,       0);
        add_row(tdon_pkg::OP_LOAD, 0,      0,      32'h7fffffff, 0,     0,  0,  0,       0);
        add_row(tdon_pkg::OP_LOAD, 0,      0,      32'h80000000, 0,     0,  0,  0,       0);
        add_row(tdon_pkg::OP_ADD,  32767,  32767,  32'h7fffffff, 0,     0,  0,  0,       0);
        add_row(tdon_pkg::OP_ADD,  -32768, -32768, 32'h80000000, 0,     0,  0,  0,       0);
        add_row(tdon_pkg::OP_ADD,  23,     59,     3932159,      0,     0,  0,  0,       0);
        add_row(tdon_pkg::OP_LOAD, 0,      0,      0,            1,     0,  0,  0,       0);
        add_row(tdon_pkg::OP_ADD,  24,     0,      0,            1,     0,  0,  0,       1);
        add_row(tdon_pkg::OP_ADD,  -24,    0,      0,            1,     0,  0,  0,       -1);
        add_row(tdon_pkg::OP_ADD,  0,      60,     0,            0,     0,  0,  0,       0);
        add_row(tdon_pkg::OP_ADD,  0,      0,      65536,        0,     0,  0,  0,       0);
        add_row(tdon_pkg::OP_LOAD, 12,     30,     1966080,      1,     12, 30, 1966080, 0);
        add_row(tdon_pkg::OP_ADD,  -1,     -1,     -65536,       0,     0,  0,  0,       0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < stim_rows.size(); i++)
        begin
            send_txn(stim_rows[i]);
            pred = advance_clock(stim_rows[i]);
            pending_times.push_back(row_typed[i] ? row_want[i] : pred);
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            it.opcode = ($urandom_range(0, 6) == 0) ? tdon_pkg::OP_LOAD : tdon_pkg::OP_ADD;
            it.hour_delta = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                          : 16'(int'($urandom_range(0, 96)) - 48);
            it.minute_delta = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                            : 16'(int'($urandom_range(0, 300)) - 150);
            it.second_delta = ($urandom_range(0, 3) == 0) ? 32'($urandom)
                            : 32'(int'($urandom_range(0, 2 * SMALL_SEC)) - SMALL_SEC);
            send_txn(it);
            pending_times.push_back(advance_clock(it));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_times.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d offsets sent (%0d loads), %0d times checked, %0d with a day carry",
                 items_sent, loads_sent, times_checked, day_moves);
        $display("output held off for %0d cycles once; %0d errors", HOLD_OFF, errors);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
